>>> rtl/gapp_pkg.sv
package gapp_pkg;

  // input word kinds (tuser)
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_SEARCH = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;
  localparam logic [1:0] KIND_NOP    = 2'd3;

  // search / readout status codes
  localparam logic [2:0] ST_FOUND         = 3'd0;
  localparam logic [2:0] ST_NO_PATH       = 3'd1;
  localparam logic [2:0] ST_START_OUTSIDE = 3'd2;
  localparam logic [2:0] ST_GOAL_OUTSIDE  = 3'd3;
  localparam logic [2:0] ST_START_BLOCKED = 3'd4;
  localparam logic [2:0] ST_GOAL_BLOCKED  = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_MARGIN = 2'd2;

  // step directions
  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  localparam int LEN_W  = 17;
  localparam int G_W    = 17;
  localparam int KEY_W  = 51;
  localparam int SUM_W  = 17;

  // open list key: {f[16:0], 0, ~g[16:0], y[7:0], x[7:0]}, smaller pops first
  typedef logic [KEY_W-1:0] key_t;

endpackage

>>> rtl/grid_astar_path_planner_top.sv
// Grid A* planner, 4-connected, unit step cost, Manhattan heuristic. A load word
// writes one obstacle bit. A readout word presents the next path cell (start
// first, goal marked by tlast) from the edge after its acceptance, or from the
// accepting edge itself when no path is stored. A search word runs one shared
// sequencer over memories with one read and one write port: a visited clearing
// pass over all MAX_WIDTH*MAX_HEIGHT cells, a zero pass over the width+height+1
// border entries of the prefix table, a read-then-write obstacle prefix-sum pass
// over the map in use, then per popped cell a heap pop with sift-down and per
// neighbour four prefix-table reads for the clearance window and, if clear, a heap
// push, and a backtrack that stores the path. The block is not ready until the
// pending result word has been taken.
module grid_astar_path_planner_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_MARGIN = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // cell_x[7:0], cell_y[15:8], obstacle[16], goal_x[24:17], goal_y[32:25]
  input  logic [39:0] s_axis_tdata_i,
  // kind[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // status[2:0], path_length[19:3], path_x[27:20], path_y[35:28]
  output logic [39:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [8:0]  cfg_data_i
);
  import gapp_pkg::*;

  localparam int NCELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int IDX_W  = $clog2(NCELLS);
  localparam int CNT_W  = $clog2(NCELLS + 1);
  localparam int CMP_W  = IDX_W + 2;
  localparam int PS_S   = MAX_WIDTH + 1;
  localparam int PS_N   = PS_S * (MAX_HEIGHT + 1);
  localparam int PS_AW  = $clog2(PS_N);

  typedef enum logic [26:0] {
    S_IDLE  = 27'h0000001, S_CHK_G = 27'h0000002, S_CHK_E = 27'h0000004,
    S_CLR   = 27'h0000008, S_PZR   = 27'h0000010, S_PZC   = 27'h0000020,
    S_PFX_A = 27'h0000040, S_PFX_B = 27'h0000080, S_SEED  = 27'h0000100,
    S_POP_A = 27'h0000200, S_POP_B = 27'h0000400, S_POP_C = 27'h0000800,
    S_SFT_A = 27'h0001000, S_SFT_B = 27'h0002000, S_SFT_C = 27'h0004000,
    S_SFT_D = 27'h0008000, S_EXP   = 27'h0010000, S_NB_A  = 27'h0020000,
    S_NB_B  = 27'h0040000, S_NB_R  = 27'h0080000, S_NB_S  = 27'h0100000,
    S_NB_T  = 27'h0200000, S_PU_A  = 27'h0400000, S_PU_B  = 27'h0800000,
    S_BT_A  = 27'h1000000, S_BT_B  = 27'h2000000, S_RD    = 27'h4000000
  } state_e;

  function automatic logic [IDX_W-1:0] cell_addr(input logic [7:0] x, input logic [7:0] y);
    cell_addr = IDX_W'(int'(y) * MAX_WIDTH + int'(x));
  endfunction

  function automatic logic [PS_AW-1:0] ps_addr(input logic [9:0] x, input logic [9:0] y);
    ps_addr = PS_AW'(int'(y) * PS_S + int'(x));
  endfunction

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    abs_diff = (a > b) ? a - b : b - a;
  endfunction

  function automatic key_t make_key(input logic [7:0] x, input logic [7:0] y,
                                    input logic [G_W-1:0] g, input logic [7:0] tx,
                                    input logic [7:0] ty);
    logic [G_W-1:0] f;
    f = g + G_W'(abs_diff(x, tx)) + G_W'(abs_diff(y, ty));
    make_key = {f, 1'b0, ~g, y, x};
  endfunction

  // memories
  logic                 obs_mem [NCELLS];
  logic                 vis_mem [NCELLS];
  logic [1:0]           par_mem [NCELLS];
  key_t                 heap_mem [NCELLS];
  logic [SUM_W-1:0]     ps_mem [PS_N];
  logic [15:0]          path_mem [NCELLS];

  logic [IDX_W-1:0] cell_ra, obs_wa, vis_wa, par_wa, heap_ra, heap_wa, path_ra, path_wa;
  logic [PS_AW-1:0] ps_ra, ps_wa;
  logic obs_we, obs_wd, vis_we, vis_wd, par_we, heap_we, ps_we, path_we;
  logic [1:0] par_wd;
  key_t heap_wd;
  logic [SUM_W-1:0] ps_wd;
  logic [15:0] path_wd;
  logic obs_rd_q, vis_rd_q;
  logic [1:0] par_rd_q;
  key_t heap_rd_q;
  logic [SUM_W-1:0] ps_rd_q;
  logic [15:0] path_rd_q;

  always_ff @(posedge clk_i) begin
    if (obs_we) obs_mem[obs_wa] <= obs_wd;
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    if (par_we) par_mem[par_wa] <= par_wd;
    if (heap_we) heap_mem[heap_wa] <= heap_wd;
    if (ps_we) ps_mem[ps_wa] <= ps_wd;
    if (path_we) path_mem[path_wa] <= path_wd;
    obs_rd_q  <= obs_mem[cell_ra];
    vis_rd_q  <= vis_mem[cell_ra];
    par_rd_q  <= par_mem[cell_ra];
    heap_rd_q <= heap_mem[heap_ra];
    ps_rd_q   <= ps_mem[ps_ra];
    path_rd_q <= path_mem[path_ra];
  end

  // control registers
  state_e state_q, state_d;
  logic [8:0] cfg_w_q, cfg_h_q;
  logic [3:0] cfg_m_q;
  logic [7:0] sx_q, sy_q, gx_q, gy_q, sx_d, sy_d, gx_d, gy_d;
  logic [7:0] cx_q, cy_q, nx_q, ny_q, cx_d, cy_d, nx_d, ny_d;
  logic [IDX_W:0] clr_q, clr_d;
  logic [8:0] px_q, py_q, px_d, py_d;
  logic [SUM_W-1:0] row_q, row_d, sum_q, sum_d;
  logic [CNT_W-1:0] open_q, open_d, pc_q, pc_d, rp_q, rp_d;
  logic [IDX_W-1:0] hi_q, hi_d;
  logic [CMP_W-1:0] hc_q, hc_d;
  key_t top_q, top_d, last_q, last_d, kc_q, kc_d, key_q, key_d;
  logic [G_W-1:0] g_q, g_d;
  logic [1:0] dir_q, dir_d, rk_q, rk_d;
  logic safe_q, safe_d, rlast_q, rlast_d;
  logic ov_q, ov_d, olast_q, olast_d;
  logic [2:0] ost_q, ost_d;
  logic [LEN_W-1:0] olen_q, olen_d;
  logic [7:0] ox_q, oy_q, ox_d, oy_d;

  logic [8:0] w, h;
  logic [3:0] m;
  logic in_acc, fin, nxt_dir;
  logic [2:0] fin_st;
  logic [7:0] in_cx, in_cy, in_gx, in_gy;
  logic in_ob;
  logic [CMP_W-1:0] child, open_c;
  logic [CNT_W-1:0] idx, pcn;
  logic [9:0] nx10, ny10, m10, xa, xb, ya, yb;
  logic inb;
  logic [SUM_W-1:0] sum_n;

  assign w = (cfg_w_q > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : cfg_w_q;
  assign h = (cfg_h_q > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : cfg_h_q;
  assign m = (int'(cfg_m_q) > MAX_MARGIN) ? 4'(MAX_MARGIN) : cfg_m_q;

  assign s_axis_tready_o = (state_q == S_IDLE) && !ov_q;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign in_cx = s_axis_tdata_i[7:0];
  assign in_cy = s_axis_tdata_i[15:8];
  assign in_ob = s_axis_tdata_i[16];
  assign in_gx = s_axis_tdata_i[24:17];
  assign in_gy = s_axis_tdata_i[32:25];

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = {4'd0, oy_q, ox_q, olen_q, ost_q};
  assign m_axis_tlast_o  = olast_q;

  assign nx10 = {2'b00, nx_q};
  assign ny10 = {2'b00, ny_q};
  assign m10  = {6'd0, m};
  assign xa = nx10 + m10 + 10'd1;
  assign xb = nx10 - m10;
  assign ya = ny10 + m10 + 10'd1;
  assign yb = ny10 - m10;
  assign open_c = CMP_W'(open_q);

  always_comb begin
    state_d = state_q;
    sx_d = sx_q; sy_d = sy_q; gx_d = gx_q; gy_d = gy_q;
    cx_d = cx_q; cy_d = cy_q; nx_d = nx_q; ny_d = ny_q;
    clr_d = clr_q; px_d = px_q; py_d = py_q; row_d = row_q; sum_d = sum_q;
    open_d = open_q; pc_d = pc_q; rp_d = rp_q; hi_d = hi_q; hc_d = hc_q;
    top_d = top_q; last_d = last_q; kc_d = kc_q; key_d = key_q; g_d = g_q;
    dir_d = dir_q; rk_d = rk_q; safe_d = safe_q; rlast_d = rlast_q;
    ov_d = ov_q; ost_d = ost_q; olen_d = olen_q; ox_d = ox_q; oy_d = oy_q;
    olast_d = olast_q;
    cell_ra = cell_addr(nx_q, ny_q);
    heap_ra = '0; ps_ra = '0; path_ra = '0;
    obs_we = 1'b0; obs_wa = cell_addr(in_cx, in_cy); obs_wd = in_ob;
    vis_we = 1'b0; vis_wa = cell_addr(nx_q, ny_q); vis_wd = 1'b1;
    par_we = 1'b0; par_wa = cell_addr(nx_q, ny_q); par_wd = dir_q;
    heap_we = 1'b0; heap_wa = hi_q; heap_wd = key_q;
    ps_we = 1'b0; ps_wa = '0; ps_wd = '0;
    path_we = 1'b0; path_wa = IDX_W'(pc_q); path_wd = {ny_q, nx_q};
    fin = 1'b0; fin_st = ST_FOUND; nxt_dir = 1'b0;
    child = '0; idx = '0; pcn = '0; inb = 1'b0; sum_n = '0;

    if (ov_q && m_axis_tready_i) ov_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (s_axis_tuser_i)
            KIND_LOAD: begin
              obs_we = (int'(in_cx) < MAX_WIDTH) && (int'(in_cy) < MAX_HEIGHT);
            end
            KIND_SEARCH: begin
              sx_d = in_cx; sy_d = in_cy; gx_d = in_gx; gy_d = in_gy;
              pc_d = '0; rp_d = '0; open_d = '0;
              cell_ra = cell_addr(in_cx, in_cy);
              if ({1'b0, in_cx} >= w || {1'b0, in_cy} >= h) begin
                fin = 1'b1; fin_st = ST_START_OUTSIDE;
              end else if ({1'b0, in_gx} >= w || {1'b0, in_gy} >= h) begin
                fin = 1'b1; fin_st = ST_GOAL_OUTSIDE;
              end else begin
                state_d = S_CHK_G;
              end
            end
            KIND_READ: begin
              if (pc_q == '0) begin
                ov_d = 1'b1; ost_d = ST_NO_PATH; olen_d = '0;
                ox_d = '0; oy_d = '0; olast_d = 1'b1;
              end else begin
                idx = (rp_q < pc_q) ? rp_q : pc_q - 1'b1;
                // path is stored goal first
                path_ra = IDX_W'(pc_q - 1'b1 - idx);
                rlast_d = (idx == pc_q - 1'b1);
                if (rp_q < pc_q) rp_d = rp_q + 1'b1;
                state_d = S_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        ov_d = 1'b1; ost_d = ST_FOUND; olen_d = LEN_W'(pc_q);
        ox_d = path_rd_q[7:0]; oy_d = path_rd_q[15:8]; olast_d = rlast_q;
        state_d = S_IDLE;
      end
      S_CHK_G: begin
        cell_ra = cell_addr(gx_q, gy_q);
        if (obs_rd_q) begin
          fin = 1'b1; fin_st = ST_START_BLOCKED;
        end else begin
          state_d = S_CHK_E;
        end
      end
      S_CHK_E: begin
        if (obs_rd_q) begin
          fin = 1'b1; fin_st = ST_GOAL_BLOCKED;
        end else begin
          clr_d = '0;
          state_d = S_CLR;
        end
      end
      S_CLR: begin
        vis_we = 1'b1; vis_wa = clr_q[IDX_W-1:0]; vis_wd = 1'b0;
        clr_d = clr_q + 1'b1;
        if (clr_q == (IDX_W+1)'(NCELLS - 1)) begin
          px_d = '0;
          state_d = S_PZR;
        end
      end
      S_PZR: begin
        ps_we = 1'b1; ps_wa = ps_addr({1'b0, px_q}, 10'd0);
        px_d = px_q + 1'b1;
        if (px_q == w) begin
          py_d = 9'd1;
          state_d = S_PZC;
        end
      end
      S_PZC: begin
        ps_we = 1'b1; ps_wa = ps_addr(10'd0, {1'b0, py_q});
        py_d = py_q + 1'b1;
        if (py_q == h) begin
          px_d = '0; py_d = '0; row_d = '0;
          state_d = S_PFX_A;
        end
      end
      S_PFX_A: begin
        cell_ra = cell_addr(px_q[7:0], py_q[7:0]);
        ps_ra = ps_addr({1'b0, px_q} + 10'd1, {1'b0, py_q});
        state_d = S_PFX_B;
      end
      S_PFX_B: begin
        // running row sum plus the entry above
        sum_n = row_q + SUM_W'(obs_rd_q);
        ps_we = 1'b1;
        ps_wa = ps_addr({1'b0, px_q} + 10'd1, {1'b0, py_q} + 10'd1);
        ps_wd = ps_rd_q + sum_n;
        row_d = sum_n;
        state_d = S_PFX_A;
        if (px_q == w - 1'b1) begin
          px_d = '0; row_d = '0;
          if (py_q == h - 1'b1) state_d = S_SEED;
          else py_d = py_q + 1'b1;
        end else begin
          px_d = px_q + 1'b1;
        end
      end
      S_SEED: begin
        vis_we = 1'b1; vis_wa = cell_addr(sx_q, sy_q);
        heap_we = 1'b1; heap_wa = '0; heap_wd = make_key(sx_q, sy_q, '0, gx_q, gy_q);
        open_d = CNT_W'(1);
        state_d = S_POP_A;
      end
      S_POP_A: begin
        heap_ra = '0;
        if (open_q == '0) begin
          fin = 1'b1; fin_st = ST_NO_PATH;
        end else begin
          state_d = S_POP_B;
        end
      end
      S_POP_B: begin
        top_d = heap_rd_q;
        heap_ra = IDX_W'(open_q - 1'b1);
        state_d = S_POP_C;
      end
      S_POP_C: begin
        last_d = heap_rd_q;
        open_d = open_q - 1'b1;
        hi_d = '0;
        state_d = S_SFT_A;
      end
      S_SFT_A: begin
        child = {1'b0, hi_q, 1'b1};
        heap_ra = child[IDX_W-1:0];
        hc_d = child;
        if (child >= open_c) begin
          heap_we = (open_q != '0); heap_wd = last_q;
          state_d = S_EXP;
        end else begin
          state_d = S_SFT_B;
        end
      end
      S_SFT_B: begin
        kc_d = heap_rd_q;
        heap_ra = IDX_W'(hc_q + 1'b1);
        if (hc_q + 1'b1 < open_c) state_d = S_SFT_C;
        else state_d = S_SFT_D;
      end
      S_SFT_C: begin
        if (heap_rd_q < kc_q) begin
          kc_d = heap_rd_q;
          hc_d = hc_q + 1'b1;
        end
        state_d = S_SFT_D;
      end
      S_SFT_D: begin
        heap_we = 1'b1;
        if (kc_q >= last_q) begin
          heap_wd = last_q;
          state_d = S_EXP;
        end else begin
          heap_wd = kc_q;
          hi_d = hc_q[IDX_W-1:0];
          state_d = S_SFT_A;
        end
      end
      S_EXP: begin
        cx_d = top_q[7:0];
        cy_d = top_q[15:8];
        g_d = ~top_q[32:16];
        if (top_q[7:0] == gx_q && top_q[15:8] == gy_q) begin
          nx_d = top_q[7:0]; ny_d = top_q[15:8]; pc_d = '0;
          state_d = S_BT_A;
        end else begin
          dir_d = DIR_LEFT;
          state_d = S_NB_A;
        end
      end
      S_NB_A: begin
        nx_d = cx_q; ny_d = cy_q;
        unique case (dir_q)
          DIR_LEFT:  begin inb = (cx_q != 8'd0); nx_d = cx_q - 8'd1; end
          DIR_RIGHT: begin inb = ({1'b0, cx_q} + 9'd1 < w); nx_d = cx_q + 8'd1; end
          DIR_UP:    begin inb = (cy_q != 8'd0); ny_d = cy_q - 8'd1; end
          DIR_DOWN:  begin inb = ({1'b0, cy_q} + 9'd1 < h); ny_d = cy_q + 8'd1; end
          default: ;
        endcase
        cell_ra = cell_addr(nx_d, ny_d);
        if (inb) state_d = S_NB_B;
        else nxt_dir = 1'b1;
      end
      S_NB_B: begin
        if (obs_rd_q || vis_rd_q) begin
          nxt_dir = 1'b1;
        end else if (nx10 >= m10 && ny10 >= m10 && nx10 + m10 < {1'b0, w}
                     && ny10 + m10 < {1'b0, h}) begin
          rk_d = '0; sum_d = '0;
          state_d = S_NB_R;
        end else begin
          safe_d = 1'b0;
          state_d = S_NB_T;
        end
      end
      S_NB_R: begin
        unique case (rk_q)
          2'd0: ps_ra = ps_addr(xa, ya);
          2'd1: ps_ra = ps_addr(xa, yb);
          2'd2: ps_ra = ps_addr(xb, ya);
          2'd3: ps_ra = ps_addr(xb, yb);
          default: ;
        endcase
        state_d = S_NB_S;
      end
      S_NB_S: begin
        // window sum: A - B - C + D, modular is exact for a zero test
        if (rk_q == 2'd1 || rk_q == 2'd2) sum_n = sum_q - ps_rd_q;
        else sum_n = sum_q + ps_rd_q;
        sum_d = sum_n;
        if (rk_q == 2'd3) begin
          safe_d = (sum_n == '0);
          state_d = S_NB_T;
        end else begin
          rk_d = rk_q + 1'b1;
          state_d = S_NB_R;
        end
      end
      S_NB_T: begin
        vis_we = 1'b1;
        key_d = make_key(nx_q, ny_q, g_q + 1'b1, gx_q, gy_q);
        if (safe_q) par_we = 1'b1;
        if (safe_q && open_q < CNT_W'(NCELLS)) begin
          hi_d = IDX_W'(open_q);
          open_d = open_q + 1'b1;
          state_d = S_PU_A;
        end else begin
          nxt_dir = 1'b1;
        end
      end
      S_PU_A: begin
        hc_d = CMP_W'((hi_q - 1'b1) >> 1);
        heap_ra = IDX_W'((hi_q - 1'b1) >> 1);
        if (hi_q == '0) begin
          heap_we = 1'b1;
          nxt_dir = 1'b1;
        end else begin
          state_d = S_PU_B;
        end
      end
      S_PU_B: begin
        heap_we = 1'b1;
        if (heap_rd_q <= key_q) begin
          nxt_dir = 1'b1;
        end else begin
          heap_wd = heap_rd_q;
          hi_d = hc_q[IDX_W-1:0];
          state_d = S_PU_A;
        end
      end
      S_BT_A: begin
        path_we = 1'b1;
        pcn = pc_q + 1'b1;
        pc_d = pcn;
        cell_ra = cell_addr(nx_q, ny_q);
        if ((nx_q == sx_q && ny_q == sy_q) || pcn >= CNT_W'(NCELLS)) begin
          fin = 1'b1; fin_st = ST_FOUND;
        end else begin
          state_d = S_BT_B;
        end
      end
      S_BT_B: begin
        unique case (par_rd_q)
          DIR_LEFT:  nx_d = nx_q + 8'd1;
          DIR_RIGHT: nx_d = nx_q - 8'd1;
          DIR_UP:    ny_d = ny_q + 8'd1;
          DIR_DOWN:  ny_d = ny_q - 8'd1;
          default: ;
        endcase
        state_d = S_BT_A;
      end
      default: state_d = S_IDLE;
    endcase

    if (nxt_dir) begin
      if (dir_q == DIR_DOWN) begin
        state_d = S_POP_A;
      end else begin
        dir_d = dir_q + 1'b1;
        state_d = S_NB_A;
      end
    end

    if (fin) begin
      ov_d = 1'b1; ost_d = fin_st; olen_d = LEN_W'(pc_d);
      ox_d = '0; oy_d = '0; olast_d = (fin_st != ST_FOUND);
      state_d = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cfg_w_q <= 9'd256;
      cfg_h_q <= 9'd256;
      cfg_m_q <= 4'd10;
      open_q  <= '0;
      pc_q    <= '0;
      rp_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      open_q  <= open_d;
      pc_q    <= pc_d;
      rp_q    <= rp_d;
      ov_q    <= ov_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_WIDTH:  cfg_w_q <= cfg_data_i;
          CFG_HEIGHT: cfg_h_q <= cfg_data_i;
          CFG_MARGIN: cfg_m_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sx_q <= sx_d; sy_q <= sy_d; gx_q <= gx_d; gy_q <= gy_d;
    cx_q <= cx_d; cy_q <= cy_d; nx_q <= nx_d; ny_q <= ny_d;
    clr_q <= clr_d; px_q <= px_d; py_q <= py_d; row_q <= row_d; sum_q <= sum_d;
    hi_q <= hi_d; hc_q <= hc_d;
    top_q <= top_d; last_q <= last_d; kc_q <= kc_d; key_q <= key_d; g_q <= g_d;
    dir_q <= dir_d; rk_q <= rk_d; safe_q <= safe_d; rlast_q <= rlast_d;
    ost_q <= ost_d; olen_q <= olen_d; ox_q <= ox_d; oy_q <= oy_d; olast_q <= olast_d;
  end

endmodule

>>> verif/tb.sv
module tb;
  import gapp_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] cx;
    logic [7:0] cy;
    logic       ob;
    logic [7:0] gx;
    logic [7:0] gy;
  } planner_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [16:0] len;
    logic [7:0]  px;
    logic [7:0]  py;
    logic        last;
  } planner_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [8:0]  cfg_data_i = '0;

  grid_astar_path_planner_top dut (.*);

  // predictor state
  int unsigned   map_w = 256, map_h = 256, margin = 10;
  bit            blocked [65536];
  bit            seen [65536];
  bit [1:0]      came_from [65536];
  int unsigned   clear_sum [257*257];
  logic [15:0]   path_cells [$];
  int unsigned   read_ptr;

  planner_word_t pending [$];
  planner_res_t  expected_res [$];
  int            send_idle_pct, recv_stall_pct;
  bit            in_fire;
  int            errors;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #100000000;
    $display("Verification failed");
    $finish;
  end

  function automatic longint unsigned open_key(int unsigned x, int unsigned y, int unsigned g,
                                               int unsigned gx, int unsigned gy);
    longint unsigned f;
    f = g + (x > gx ? x - gx : gx - x) + (y > gy ? y - gy : gy - y);
    return (f << 34) | (longint'(17'h1FFFF - g) << 16) | (y << 8) | x;
  endfunction

  function automatic int unsigned window_sum(int unsigned x0, int unsigned y0,
                                             int unsigned x1, int unsigned y1);
    return clear_sum[(y1+1)*257 + x1+1] - clear_sum[y0*257 + x1+1]
         - clear_sum[(y1+1)*257 + x0] + clear_sum[y0*257 + x0];
  endfunction

  function automatic logic [2:0] plan_path(int unsigned sx, int unsigned sy,
                                           int unsigned gx, int unsigned gy);
    int unsigned w, h, m, x, y, g, idx, best;
    int nx, ny;
    longint unsigned open_list [$];
    longint unsigned k;
    logic [1:0] pd;
    w = map_w > 256 ? 256 : map_w;
    h = map_h > 256 ? 256 : map_h;
    m = margin;
    foreach (seen[i]) seen[i] = 1'b0;
    path_cells.delete();
    read_ptr = 0;
    if (sx >= w || sy >= h) return ST_START_OUTSIDE;
    if (gx >= w || gy >= h) return ST_GOAL_OUTSIDE;
    if (blocked[sy*256 + sx]) return ST_START_BLOCKED;
    if (blocked[gy*256 + gx]) return ST_GOAL_BLOCKED;
    foreach (clear_sum[i]) clear_sum[i] = 0;
    for (y = 0; y < h; y++)
      for (x = 0; x < w; x++)
        clear_sum[(y+1)*257 + x+1] = blocked[y*256 + x] + clear_sum[y*257 + x+1]
                                   + clear_sum[(y+1)*257 + x] - clear_sum[y*257 + x];
    seen[sy*256 + sx] = 1'b1;
    open_list.insert(open_list.size(), open_key(sx, sy, 0, gx, gy));
    while (open_list.size() > 0) begin
      best = 0;
      foreach (open_list[i]) if (open_list[i] < open_list[best]) best = i;
      k = open_list[best];
      open_list.delete(best);
      x = k[7:0];
      y = k[15:8];
      g = 17'h1FFFF - k[32:16];
      if (x == gx && y == gy) begin
        forever begin
          path_cells.push_front({y[7:0], x[7:0]});
          if (x == sx && y == sy) break;
          pd = came_from[y*256 + x];
          case (pd)
            DIR_LEFT:  x = x + 1;
            DIR_RIGHT: x = x - 1;
            DIR_UP:    y = y + 1;
            default:   y = y - 1;
          endcase
        end
        return ST_FOUND;
      end
      for (int d = 0; d < 4; d++) begin
        nx = x; ny = y;
        case (d[1:0])
          DIR_LEFT:  nx = nx - 1;
          DIR_RIGHT: nx = nx + 1;
          DIR_UP:    ny = ny - 1;
          default:   ny = ny + 1;
        endcase
        if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
        idx = ny*256 + nx;
        if (blocked[idx] || seen[idx]) continue;
        if (nx >= m && ny >= m && nx + m < w && ny + m < h
            && window_sum(nx-m, ny-m, nx+m, ny+m) == 0) begin
          came_from[idx] = d[1:0];
          open_list.insert(open_list.size(), open_key(nx, ny, g+1, gx, gy));
        end
        seen[idx] = 1'b1;
      end
    end
    return ST_NO_PATH;
  endfunction

  function automatic void predict_word(planner_word_t wd);
    planner_res_t r;
    int unsigned i;
    r = '0;
    case (wd.kind)
      KIND_LOAD: blocked[wd.cy*256 + wd.cx] = wd.ob;
      KIND_SEARCH: begin
        r.status = plan_path(wd.cx, wd.cy, wd.gx, wd.gy);
        r.len = 17'(path_cells.size());
        r.last = r.status != ST_FOUND;
        expected_res.insert(expected_res.size(), r);
      end
      KIND_READ: begin
        if (path_cells.size() == 0) begin
          r.status = ST_NO_PATH;
          r.last = 1'b1;
        end else begin
          i = read_ptr < path_cells.size() ? read_ptr : path_cells.size() - 1;
          r.status = ST_FOUND;
          r.len = 17'(path_cells.size());
          r.px = path_cells[i][7:0];
          r.py = path_cells[i][15:8];
          r.last = i == path_cells.size() - 1;
          if (read_ptr < path_cells.size()) read_ptr++;
        end
        expected_res.insert(expected_res.size(), r);
      end
      default: ;
    endcase
  endfunction

  // driver
  always @(negedge clk_i) begin
    planner_word_t wd;
    if (rst_ni && (!s_axis_tvalid_i || in_fire)) begin
      if (pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        wd = pending.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tuser_i  <= wd.kind;
        s_axis_tdata_i  <= {7'b0, wd.gy, wd.gx, wd.ob, wd.cy, wd.cx};
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
    m_axis_tready_i <= $urandom_range(99) >= recv_stall_pct;
  end

  // monitor
  always @(posedge clk_i) begin
    planner_word_t wd;
    planner_res_t  e;
    in_fire = s_axis_tvalid_i && s_axis_tready_o;
    if (in_fire) begin
      wd.kind = s_axis_tuser_i;
      {wd.gy, wd.gx, wd.ob, wd.cy, wd.cx} = s_axis_tdata_i[32:0];
      predict_word(wd);
    end
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_res.size() == 0) begin
        $error("unexpected result word %h", m_axis_tdata_o);
        errors++;
      end else begin
        e = expected_res.pop_front();
        if (m_axis_tdata_o[2:0] !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, m_axis_tdata_o[2:0]); errors++;
        end
        if (m_axis_tdata_o[19:3] !== e.len) begin
          $error("path_length: expected %0d, got %0d", e.len, m_axis_tdata_o[19:3]); errors++;
        end
        if (m_axis_tdata_o[27:20] !== e.px) begin
          $error("path_x: expected %0d, got %0d", e.px, m_axis_tdata_o[27:20]); errors++;
        end
        if (m_axis_tdata_o[35:28] !== e.py) begin
          $error("path_y: expected %0d, got %0d", e.py, m_axis_tdata_o[35:28]); errors++;
        end
        if (m_axis_tlast_o !== e.last) begin
          $error("last_cell: expected %0d, got %0d", e.last, m_axis_tlast_o); errors++;
        end
      end
    end
  end

  function automatic planner_word_t mk(logic [1:0] kind, int cx, int cy, int ob = 0,
                                       int gx = 0, int gy = 0);
    planner_word_t wd;
    wd.kind = kind; wd.cx = 8'(cx); wd.cy = 8'(cy); wd.ob = 1'(ob);
    wd.gx = 8'(gx); wd.gy = 8'(gy);
    return wd;
  endfunction

  task automatic drain();
    while (pending.size() > 0 || s_axis_tvalid_i || expected_res.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    @(negedge clk_i);
    cfg_we_i = 1'b1; cfg_idx_i = idx; cfg_data_i = 9'(val);
    case (idx)
      CFG_WIDTH:  map_w = val;
      CFG_HEIGHT: map_h = val;
      default:    margin = val;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_map(int unsigned w, int unsigned h, int unsigned m, int mode);
    drain();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_MARGIN, m);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
      default: begin send_idle_pct = 27; recv_stall_pct = 27; end
    endcase
  endtask

  // loads the whole area in use, then searches with readouts
  task automatic random_phase(int unsigned w, int unsigned h, int unsigned m,
                              int dens, int searches, int mode);
    int unsigned ew, eh, sx, sy, gx, gy;
    set_map(w, h, m, mode);
    ew = w > 256 ? 256 : w;
    eh = h > 256 ? 256 : h;
    for (int y = 0; y < eh; y++)
      for (int x = 0; x < ew; x++) begin
        pending.insert(pending.size(), mk(KIND_LOAD, x, y, int'($urandom_range(99) < dens)));
        if ($urandom_range(49) == 0)
          pending.insert(pending.size(), mk(KIND_LOAD, $urandom_range(255),
                                            $urandom_range(255), $urandom_range(1)));
      end
    for (int s = 0; s < searches; s++) begin
      sx = $urandom_range(ew-1); sy = $urandom_range(eh-1);
      gx = $urandom_range(ew-1); gy = $urandom_range(eh-1);
      // start and goal mostly made free
      if ($urandom_range(4) != 0) begin
        pending.insert(pending.size(), mk(KIND_LOAD, sx, sy, 0));
        pending.insert(pending.size(), mk(KIND_LOAD, gx, gy, 0));
      end
      if ($urandom_range(7) == 0) gx = $urandom_range(255);
      pending.insert(pending.size(), mk(KIND_SEARCH, sx, sy, $urandom_range(1), gx, gy));
      repeat ($urandom_range(ew + eh, ew + eh + 6))
        pending.insert(pending.size(), mk(KIND_READ, $urandom_range(255), $urandom_range(255),
                                          $urandom_range(1), $urandom_range(255),
                                          $urandom_range(255)));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_map(3, 2, 0, 0);
    pending.insert(pending.size(), mk(KIND_LOAD, 255, 255, 1));
    for (int y = 0; y < 2; y++)
      for (int x = 0; x < 3; x++)
        pending.insert(pending.size(), mk(KIND_LOAD, x, y, int'(x == 1 && y == 0)));
    pending.insert(pending.size(), mk(KIND_READ, 0, 0));
    pending.insert(pending.size(), mk(KIND_SEARCH, 3, 0, 0, 0, 0));
    pending.insert(pending.size(), mk(KIND_SEARCH, 0, 0, 0, 0, 2));
    pending.insert(pending.size(), mk(KIND_SEARCH, 1, 0, 0, 0, 0));
    pending.insert(pending.size(), mk(KIND_SEARCH, 0, 0, 0, 1, 0));
    pending.insert(pending.size(), mk(KIND_SEARCH, 2, 1, 0, 2, 1));
    repeat (2) pending.insert(pending.size(), mk(KIND_READ, 0, 0));
    pending.insert(pending.size(), mk(KIND_SEARCH, 0, 0, 0, 2, 0));
    repeat (6) pending.insert(pending.size(), mk(KIND_READ, 0, 0));
    pending.insert(pending.size(), mk(KIND_NOP, 255, 255, 1, 255, 255));

    random_phase(511, 1, 0, 4, 1, 1);
    random_phase(1, 256, 0, 4, 1, 2);
    random_phase(16, 16, 1, 3, 2, 3);
    random_phase(12, 10, 0, 20, 2, 0);
    random_phase(9, 7, 15, 10, 1, 1);

    // width zero: every start lies outside
    set_map(0, 5, 0, 2);
    pending.insert(pending.size(), mk(KIND_SEARCH, 0, 0, 0, 0, 0));
    pending.insert(pending.size(), mk(KIND_READ, 0, 0));
    drain();

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/gapp_pkg.sv
rtl/grid_astar_path_planner_top.sv
verif/tb.sv
